@@ rtl/lasq_pkg.sv @@
// lasq_pkg: types and constants for the led alert pattern sequencer
// used by led_alert_pattern_sequencer_core; no dependencies

package lasq_pkg;

	localparam int unsigned REG_W  = 16;
	localparam int unsigned CODE_W = 3;
	localparam int unsigned LED_N  = 4;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_LOADING_DELAY  = 2'd0,
		REG_FALLING_PERIOD = 2'd1,
		REG_CRASH_PERIOD   = 2'd2,
		REG_ERROR_PERIOD   = 2'd3
	} reg_index_t;

	// alert patterns, same encoding as the request code
	typedef enum logic [CODE_W-1:0] {
		MODE_RUNNING = 3'd0,
		MODE_LOADING = 3'd1,
		MODE_FALLING = 3'd2,
		MODE_CRASH   = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	// item function
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// led sets, bit0 yellow, bit1 red, bit2 blue, bit3 green
	localparam logic [LED_N-1:0] LEDS_FALLING    = 4'b0101;
	localparam logic [LED_N-1:0] LEDS_CRASH      = 4'b1111;
	localparam logic [LED_N-1:0] LEDS_ERROR      = 4'b0010;
	localparam logic [LED_N-1:0] LEDS_GREEN_ONLY = 4'b1000;
	localparam logic [LED_N-1:0] LEDS_ALL        = 4'b1111;

	// reset values of the registers
	localparam logic [REG_W-1:0] RST_LOADING_DELAY  = 16'd250;
	localparam logic [REG_W-1:0] RST_FALLING_PERIOD = 16'd200;
	localparam logic [REG_W-1:0] RST_CRASH_PERIOD   = 16'd100;
	localparam logic [REG_W-1:0] RST_ERROR_PERIOD   = 16'd500;

	typedef struct packed {
		logic              func;
		logic [CODE_W-1:0] alert_code;
	} item_t;

	typedef struct packed {
		logic led_yellow;
		logic led_red;
		logic led_blue;
		logic led_green;
	} result_t;

endpackage

@@ rtl/led_alert_pattern_sequencer_core.sv @@
// led_alert_pattern_sequencer_core: top level of the led alert pattern sequencer
// depends on lasq_pkg for item/result structs, mode codes and led sets

// Drives four LEDs (yellow, red, blue, green) in one of five alert patterns.
// Each beat on the item channel is either a tick (func = 0) or an alert request
// (func = 1, alert_code selects running, loading, falling, crash or error; codes
// five to seven select running). Every item yields exactly one result beat with
// the LED levels after that item. A request restarts the pattern: running shows
// green only, falling starts with yellow and blue, crash with all four, error
// with red alone, loading keeps the LEDs as they are. Outside running, ticks
// advance a counter of COUNT_WIDTH bits; when it reaches the pattern's period
// the pattern acts and the counter restarts. A period of zero acts on the next
// tick, a period the counter cannot reach acts when the counter saturates.
// Loading walks eight phases: half the delay then light one LED, the full delay
// then clear it, in yellow, red, blue, green order. Timing: an accepted item is
// held in the input register; when it moves on, its result is loaded into the
// result register and presented from then on. The block accepts one item every
// cycle as long as results are taken; a stalled result holds the input register,
// and once that is full item_stall rises. The pattern state update (one counter
// increment and compare) sits between the two registers. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; there is no read-back.

module led_alert_pattern_sequencer_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  lasq_pkg::item_t                     item,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output lasq_pkg::result_t                   result,
	// configuration writes
	input  logic                                cfg_we,
	input  lasq_pkg::reg_index_t                cfg_index,
	input  logic [lasq_pkg::REG_W-1:0]          cfg_data
);

	// compare width covers both the counter and a 16-bit period
	localparam int unsigned CMP_W = (COUNT_WIDTH > lasq_pkg::REG_W) ?
		COUNT_WIDTH : lasq_pkg::REG_W;

	// configuration registers
	logic [lasq_pkg::REG_W-1:0] loading_delay_q;
	logic [lasq_pkg::REG_W-1:0] falling_period_q;
	logic [lasq_pkg::REG_W-1:0] crash_period_q;
	logic [lasq_pkg::REG_W-1:0] error_period_q;

	// pattern state
	lasq_pkg::mode_t            mode_q, mode_d;
	logic [2:0]                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]     count_q, count_d;
	logic [lasq_pkg::LED_N-1:0] leds_q, leds_d;

	// input stage and result stage
	logic                       valid_s1;
	lasq_pkg::item_t            item_s1;
	logic                       result_valid_q;
	lasq_pkg::result_t          result_q;

	logic advance;
	logic take;

	// the s1 item moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	// take a new beat whenever s1 is empty or moving on this cycle
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loading_delay_q  <= lasq_pkg::RST_LOADING_DELAY;
			falling_period_q <= lasq_pkg::RST_FALLING_PERIOD;
			crash_period_q   <= lasq_pkg::RST_CRASH_PERIOD;
			error_period_q   <= lasq_pkg::RST_ERROR_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lasq_pkg::REG_LOADING_DELAY:  loading_delay_q  <= cfg_data;
				lasq_pkg::REG_FALLING_PERIOD: falling_period_q <= cfg_data;
				lasq_pkg::REG_CRASH_PERIOD:   crash_period_q   <= cfg_data;
				lasq_pkg::REG_ERROR_PERIOD:   error_period_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// pattern step for the item in s1
	logic [lasq_pkg::REG_W-1:0] period;
	logic [COUNT_WIDTH-1:0]     count_inc;
	logic                       elapsed;
	logic [lasq_pkg::LED_N-1:0] phase_bit;

	always_comb begin
		// period of the active pattern; loading alternates half and full delay
		unique case (mode_q)
			lasq_pkg::MODE_LOADING: period = phase_q[0] ? loading_delay_q :
				(loading_delay_q >> 1);
			lasq_pkg::MODE_FALLING: period = falling_period_q;
			lasq_pkg::MODE_CRASH:   period = crash_period_q;
			lasq_pkg::MODE_ERROR:   period = error_period_q;
			default:                period = '0;
		endcase

		// count never rests at its maximum, so the increment cannot wrap
		count_inc = count_q + 1'b1;
		elapsed   = (CMP_W'(count_inc) >= CMP_W'(period)) || (&count_inc);
		phase_bit = lasq_pkg::LED_N'(1) << phase_q[2:1];

		mode_d  = mode_q;
		phase_d = phase_q;
		count_d = count_q;
		leds_d  = leds_q;

		if (item_s1.func == lasq_pkg::FUNC_REQUEST) begin
			phase_d = '0;
			count_d = '0;
			unique case (item_s1.alert_code)
				lasq_pkg::MODE_LOADING: begin
					mode_d = lasq_pkg::MODE_LOADING;
				end
				lasq_pkg::MODE_FALLING: begin
					mode_d = lasq_pkg::MODE_FALLING;
					leds_d = lasq_pkg::LEDS_FALLING;
				end
				lasq_pkg::MODE_CRASH: begin
					mode_d = lasq_pkg::MODE_CRASH;
					leds_d = lasq_pkg::LEDS_CRASH;
				end
				lasq_pkg::MODE_ERROR: begin
					mode_d = lasq_pkg::MODE_ERROR;
					leds_d = lasq_pkg::LEDS_ERROR;
				end
				// running and the unknown codes
				default: begin
					mode_d = lasq_pkg::MODE_RUNNING;
					leds_d = lasq_pkg::LEDS_GREEN_ONLY;
				end
			endcase
		end else if (mode_q != lasq_pkg::MODE_RUNNING) begin
			count_d = elapsed ? '0 : count_inc;
			if (elapsed) begin
				unique case (mode_q)
					lasq_pkg::MODE_LOADING: begin
						// even phase lights, odd phase clears
						leds_d  = phase_q[0] ? (leds_q & ~phase_bit) :
							(leds_q | phase_bit);
						phase_d = phase_q + 1'b1;
					end
					lasq_pkg::MODE_ERROR: begin
						leds_d = leds_q ^ lasq_pkg::LEDS_ERROR;
					end
					// falling and crash toggle everything
					default: begin
						leds_d = leds_q ^ lasq_pkg::LEDS_ALL;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lasq_pkg::MODE_RUNNING;
			phase_q <= '0;
			count_q <= '0;
			leds_q  <= lasq_pkg::LEDS_GREEN_ONLY;
		end else if (advance) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			count_q <= count_d;
			leds_q  <= leds_d;
		end
	end

	// result register, holds its beat while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.led_yellow <= leds_d[0];
			result_q.led_red    <= leds_d[1];
			result_q.led_blue   <= leds_d[2];
			result_q.led_green  <= leds_d[3];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
